// ----- rtl/rcmt_pkg.sv -----
// Shared constants and the config register enum for the clump member transform.
package rcmt_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int POS_FRAC = 8;
	localparam int QUAT_FRAC = 14;
	localparam int CFG_WIDTH = 64;
	localparam int IDX_WIDTH = 16;

	typedef enum logic [1:0] {
		REG_POSITION    = 2'd0,
		REG_ORIENTATION = 2'd1,
		REG_VELOCITY    = 2'd2,
		REG_ANG_VEL     = 2'd3
	} cfg_reg_t;

endpackage

// ----- rtl/rigid_clump_member_transform_top.sv -----
// Top level of the clump member transform: config registers, stream ports, pipeline.
//
// Usage: write the clump pose and velocities through cfg_we/cfg_index/cfg_data while
// no beat is in flight. Member beats enter on s_axis_* and results leave on m_axis_*,
// one result beat per input beat, in order.
// Pipeline: six register stages. Throughput: one beat per cycle while m_axis_tready does
// not stall the pipeline; each stage holds one multiply or one round-and-add step.
// The whole pipeline advances only when its last stage is empty or being taken, so a
// stall on m_axis_tready holds every stage and drops s_axis_tready; nothing is lost.
// Reset clears all valid bits and sets the clump orientation to identity (to zero with
// W above 16) and the other clump registers to zero.
// Values are W-bit signed; with W above 16 the packed orientation keeps only
// the bits that fit in 64 bits; the bits beyond read as zero.
module rigid_clump_member_transform_top import rcmt_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// member_index, rel_pos_x/y/z, rel_quat_w/x/y/z
	input  logic [((IDX_WIDTH+7*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// out_member_index, world_pos_x/y/z, world_quat_w/x/y/z, member_vel_x/y/z
	output logic [((IDX_WIDTH+10*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data
);

	localparam int W = VALUE_WIDTH;
	localparam int QRESET_SH = 3 * W + QUAT_FRAC;

	logic [CFG_WIDTH-1:0] pos_q, ori_q, vel_q, ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			ang_q <= '0;
			ori_q <= (QRESET_SH < CFG_WIDTH) ? (CFG_WIDTH'(1) << QRESET_SH) : '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POSITION:    pos_q <= cfg_data;
				REG_ORIENTATION: ori_q <= cfg_data;
				REG_VELOCITY:    vel_q <= cfg_data;
				REG_ANG_VEL:     ang_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [W-1:0] slc(input logic [CFG_WIDTH-1:0] r, input int k);
		logic [CFG_WIDTH+32*4-1:0] e;
		e = {{(32*4){1'b0}}, r};
		return e[k*W +: W];
	endfunction

	logic signed [W-1:0] cq [4], cp [3], cv [3], cw [3], rp [3], rq [4];
	always_comb begin
		for (int i = 0; i < 4; i++) cq[i] = slc(ori_q, 3 - i);
		for (int i = 0; i < 3; i++) begin
			cp[i] = slc(pos_q, 2 - i);
			cv[i] = slc(vel_q, 2 - i);
			cw[i] = slc(ang_q, 2 - i);
			rp[i] = s_axis_tdata[IDX_WIDTH + i*W +: W];
		end
		for (int i = 0; i < 4; i++) rq[i] = s_axis_tdata[IDX_WIDTH + (3+i)*W +: W];
	end

	logic adv, pv;
	logic [IDX_WIDTH-1:0] pidx;
	logic [W-1:0] res [10];

	assign adv = !pv || m_axis_tready;
	assign s_axis_tready = adv;

	rcmt_pipe #(.W(W)) u_pipe (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(s_axis_tvalid), .in_idx(s_axis_tdata[IDX_WIDTH-1:0]),
		.rp(rp), .rq(rq), .cq(cq), .cp(cp), .cv(cv), .cw(cw),
		.out_valid(pv), .out_idx(pidx), .res(res)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[IDX_WIDTH-1:0] = pidx;
		for (int i = 0; i < 10; i++) m_axis_tdata[IDX_WIDTH + i*W +: W] = res[i];
	end
	assign m_axis_tvalid = pv;

`ifndef ASSERT_OFF
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");
`endif

endmodule

// ----- rtl/rcmt_pipe.sv -----
// Pipelined datapath: rotation matrix, rotated offset, Hamilton product, velocity.
module rcmt_pipe import rcmt_pkg::*; #(
	parameter int W = VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [IDX_WIDTH-1:0]  in_idx,
	input  logic signed [W-1:0]   rp [3],
	input  logic signed [W-1:0]   rq [4],
	input  logic signed [W-1:0]   cq [4],
	input  logic signed [W-1:0]   cp [3],
	input  logic signed [W-1:0]   cv [3],
	input  logic signed [W-1:0]   cw [3],
	output logic                  out_valid,
	output logic [IDX_WIDTH-1:0]  out_idx,
	output logic [W-1:0]          res [10]
);

	localparam int PW = 2 * W;
	// extra width; sums before saturation are MW+W bits wide
	localparam int MW = PW - QUAT_FRAC + 4;

	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p, input int s);
		logic signed [PW-1:0] t;
		t = p + (PW'(1) <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [MW+W-1:0] v);
		logic signed [MW+W-1:0] hi, lo;
		hi = (MW+W)'((1 <<< (W - 1)) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[W-1:0];
		if (v < lo) return lo[W-1:0];
		return v[W-1:0];
	endfunction

	// Stage 1: clump quaternion pair products and Hamilton products
	logic signed [PW-1:0] qq_s1 [9];
	logic signed [PW-1:0] hp_s1 [16];
	logic signed [W-1:0]  rp_s1 [3];
	logic [IDX_WIDTH-1:0] idx_s1;
	logic                 v_s1;
	// Stage 2: matrix and quaternion result
	logic signed [W-1:0]  m_s2 [9];
	logic signed [W-1:0]  rp_s2 [3];
	logic signed [W-1:0]  wq_s2 [4];
	logic [IDX_WIDTH-1:0] idx_s2;
	logic                 v_s2;
	// Stage 3: matrix-vector products
	logic signed [PW-1:0] mv_s3 [9];
	logic signed [W-1:0]  wq_s3 [4];
	logic [IDX_WIDTH-1:0] idx_s3;
	logic                 v_s3;
	// Stage 4: offset, position, saturated offset
	logic signed [W-1:0]  wp_s4 [3];
	logic signed [W-1:0]  d_s4 [3];
	logic signed [W-1:0]  wq_s4 [4];
	logic [IDX_WIDTH-1:0] idx_s4;
	logic                 v_s4;
	// Stage 5: cross products
	logic signed [PW-1:0] cr_s5 [6];
	logic signed [W-1:0]  wp_s5 [3];
	logic signed [W-1:0]  wq_s5 [4];
	logic [IDX_WIDTH-1:0] idx_s5;
	logic                 v_s5;
	// Stage 6: outputs
	logic [W-1:0]         res_s6 [10];
	logic [IDX_WIDTH-1:0] idx_s6;
	logic                 v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	// quaternion index: 0=w 1=x 2=y 3=z
	always_ff @(posedge clk) begin
		if (adv) begin
			// yy zz xy wz xz wy xx yz wx
			qq_s1[0] <= PW'(cq[2]) * PW'(cq[2]);
			qq_s1[1] <= PW'(cq[3]) * PW'(cq[3]);
			qq_s1[2] <= PW'(cq[1]) * PW'(cq[2]);
			qq_s1[3] <= PW'(cq[0]) * PW'(cq[3]);
			qq_s1[4] <= PW'(cq[1]) * PW'(cq[3]);
			qq_s1[5] <= PW'(cq[0]) * PW'(cq[2]);
			qq_s1[6] <= PW'(cq[1]) * PW'(cq[1]);
			qq_s1[7] <= PW'(cq[2]) * PW'(cq[3]);
			qq_s1[8] <= PW'(cq[0]) * PW'(cq[1]);
			for (int a = 0; a < 4; a++)
				for (int b = 0; b < 4; b++)
					hp_s1[a*4+b] <= PW'(cq[a]) * PW'(rq[b]);
			rp_s1 <= rp;
			idx_s1 <= in_idx;
		end
	end

	logic signed [MW+W-1:0] r [9];
	logic signed [MW+W-1:0] one;
	always_comb begin
		for (int k = 0; k < 9; k++)
			r[k] = (MW+W)'(rnd(qq_s1[k], QUAT_FRAC));
		one = (MW+W)'(1) <<< QUAT_FRAC;
	end

	function automatic logic signed [MW+W-1:0] h(input int a, input int b);
		return (MW+W)'(rnd(hp_s1[a*4+b], QUAT_FRAC));
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0] <= sat(one - 2 * (r[0] + r[1]));
			m_s2[1] <= sat(2 * (r[2] - r[3]));
			m_s2[2] <= sat(2 * (r[4] + r[5]));
			m_s2[3] <= sat(2 * (r[2] + r[3]));
			m_s2[4] <= sat(one - 2 * (r[6] + r[1]));
			m_s2[5] <= sat(2 * (r[7] - r[8]));
			m_s2[6] <= sat(2 * (r[4] - r[5]));
			m_s2[7] <= sat(2 * (r[7] + r[8]));
			m_s2[8] <= sat(one - 2 * (r[6] + r[0]));
			wq_s2[0] <= sat(h(0,0) - h(1,1) - h(2,2) - h(3,3));
			wq_s2[1] <= sat(h(0,1) + h(1,0) + h(2,3) - h(3,2));
			wq_s2[2] <= sat(h(0,2) - h(1,3) + h(2,0) + h(3,1));
			wq_s2[3] <= sat(h(0,3) + h(1,2) - h(2,1) + h(3,0));
			rp_s2 <= rp_s1;
			idx_s2 <= idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					mv_s3[i*3+j] <= PW'(m_s2[i*3+j]) * PW'(rp_s2[j]);
			wq_s3 <= wq_s2;
			idx_s3 <= idx_s2;
		end
	end

	logic signed [MW+W-1:0] o [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			o[i] = (MW+W)'(rnd(mv_s3[i*3], QUAT_FRAC)) + (MW+W)'(rnd(mv_s3[i*3+1], QUAT_FRAC))
				+ (MW+W)'(rnd(mv_s3[i*3+2], QUAT_FRAC));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				wp_s4[i] <= sat(o[i] + (MW+W)'(cp[i]));
				d_s4[i] <= sat(o[i]);
			end
			wq_s4 <= wq_s3;
			idx_s4 <= idx_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s5[0] <= PW'(cw[1]) * PW'(d_s4[2]);
			cr_s5[1] <= PW'(cw[2]) * PW'(d_s4[1]);
			cr_s5[2] <= PW'(cw[2]) * PW'(d_s4[0]);
			cr_s5[3] <= PW'(cw[0]) * PW'(d_s4[2]);
			cr_s5[4] <= PW'(cw[0]) * PW'(d_s4[1]);
			cr_s5[5] <= PW'(cw[1]) * PW'(d_s4[0]);
			wp_s5 <= wp_s4;
			wq_s5 <= wq_s4;
			idx_s5 <= idx_s4;
		end
	end

	logic signed [MW+W-1:0] c [6];
	always_comb begin
		for (int k = 0; k < 6; k++)
			c[k] = (MW+W)'(rnd(cr_s5[k], POS_FRAC));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) res_s6[i] <= wp_s5[i];
			for (int i = 0; i < 4; i++) res_s6[3+i] <= wq_s5[i];
			res_s6[7] <= sat((MW+W)'(cv[0]) + c[0] - c[1]);
			res_s6[8] <= sat((MW+W)'(cv[1]) + c[2] - c[3]);
			res_s6[9] <= sat((MW+W)'(cv[2]) + c[4] - c[5]);
			idx_s6 <= idx_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_idx = idx_s6;
	assign res = res_s6;

endmodule
